/* hw/rtl/twsc_pkg.sv */
// twsc_pkg: shared types, codes and constant tables of the tunable white scene controller.
// Used by every module under hw/rtl; depends on nothing.
package twsc_pkg;

	localparam int BREATH_STEPS_DEF = 190;
	localparam int BPOS_W           = 8;
	localparam int LUX_W            = 16;
	localparam int BRIGHT_W         = 7;
	localparam int DUTY_W           = 8;
	localparam int CFG_ADDR_W       = 3;
	localparam int CFG_DATA_W       = 16;
	localparam int RECIP_W          = 20;
	localparam int RECIP_SHIFT      = 19;
	localparam int RECIP_100        = 5243;   // ceil(2^19 / 100), exact for products up to 25500

	localparam logic [BRIGHT_W-1:0] BRIGHT_MAX = 7'd100;

	typedef enum logic [2:0] {
		FN_SCENE_TICK   = 3'd0,
		FN_CONTROL_TICK = 3'd1,
		FN_LIGHTING     = 3'd2,
		FN_STRESS       = 3'd3,
		FN_INTERVENTION = 3'd4
	} func_t;

	typedef enum logic [2:0] {
		SC_OFF       = 3'd0,
		SC_CIRCADIAN = 3'd1,
		SC_WORK      = 3'd2,
		SC_DESTRESS  = 3'd3,
		SC_BREATHING = 3'd4,
		SC_SUNSET    = 3'd5,
		SC_SUNRISE   = 3'd6
	} scene_t;

	localparam logic [CFG_ADDR_W-1:0] CFG_TARGET_DEFAULT = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] CFG_TARGET_DESTRESS = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] CFG_TARGET_SUNSET  = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] CFG_LUX_BAND       = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] CFG_BRIGHT_FLOOR   = 3'd4;
	localparam logic [CFG_ADDR_W-1:0] CFG_BRIGHT_STEP    = 3'd5;

	typedef struct packed {
		logic [LUX_W-1:0]    target_default;
		logic [LUX_W-1:0]    target_destress;
		logic [LUX_W-1:0]    target_sunset;
		logic [LUX_W-1:0]    band;
		logic [BRIGHT_W-1:0] floor_pct;
		logic [4:0]          step_pct;
	} cfg_t;

	typedef struct packed {
		logic [7:0]       intervention_code;
		logic [7:0]       stress_value;
		logic [7:0]       brightness_cmd;
		logic [7:0]       scene_code;
		logic [LUX_W-1:0] lux_sample;
		logic [4:0]       hour_of_day;
		logic             switch_level;
		logic [2:0]       func;
	} item_t;

	typedef struct packed {
		logic                en;
		logic [DUTY_W-1:0]   base_warm;
		logic [DUTY_W-1:0]   base_cool;
		logic [BRIGHT_W-1:0] bright;
	} drive_t;

	typedef struct packed {
		drive_t              drv;
		scene_t              scene;
		logic [BRIGHT_W-1:0] bright;
	} stage_t;

	function automatic logic [DUTY_W-1:0] base_warm(input scene_t s);
		logic [DUTY_W-1:0] r;
		case (s)
			SC_OFF:       r = 8'd0;
			SC_CIRCADIAN: r = 8'd128;
			SC_WORK:      r = 8'd32;
			SC_DESTRESS:  r = 8'd255;
			SC_BREATHING: r = 8'd180;
			SC_SUNSET:    r = 8'd200;
			SC_SUNRISE:   r = 8'd255;
			default:      r = 8'd0;
		endcase
		return r;
	endfunction

	function automatic logic [DUTY_W-1:0] base_cool(input scene_t s);
		logic [DUTY_W-1:0] r;
		case (s)
			SC_OFF:       r = 8'd0;
			SC_CIRCADIAN: r = 8'd255;
			SC_WORK:      r = 8'd255;
			SC_DESTRESS:  r = 8'd32;
			SC_BREATHING: r = 8'd60;
			SC_SUNSET:    r = 8'd16;
			SC_SUNRISE:   r = 8'd255;
			default:      r = 8'd0;
		endcase
		return r;
	endfunction

	// brightness scaled by 2^19/100, so duty = (base * recip) >> 19
	function automatic logic [RECIP_W-1:0] recip(input logic [BRIGHT_W-1:0] b);
		logic [BRIGHT_W-1:0] bc;
		bc = (b > BRIGHT_MAX) ? BRIGHT_MAX : b;
		return RECIP_W'(32'(bc) * RECIP_100);
	endfunction

endpackage

/* hw/rtl/twsc_cfg.sv */
// twsc_cfg: configuration register file, written through the plain write port.
// Depends on twsc_pkg.
module twsc_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [twsc_pkg::CFG_ADDR_W-1:0]   cfg_addr,
	input  logic [twsc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	output twsc_pkg::cfg_t                    cfg
);

	twsc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_default  <= 16'd500;
			cfg_q.target_destress <= 16'd150;
			cfg_q.target_sunset   <= 16'd100;
			cfg_q.band            <= 16'd100;
			cfg_q.floor_pct       <= 7'd20;
			cfg_q.step_pct        <= 5'd5;
		end else if (cfg_we) begin
			case (cfg_addr)
				twsc_pkg::CFG_TARGET_DEFAULT:  cfg_q.target_default  <= cfg_wdata;
				twsc_pkg::CFG_TARGET_DESTRESS: cfg_q.target_destress <= cfg_wdata;
				twsc_pkg::CFG_TARGET_SUNSET:   cfg_q.target_sunset   <= cfg_wdata;
				twsc_pkg::CFG_LUX_BAND:        cfg_q.band            <= cfg_wdata;
				twsc_pkg::CFG_BRIGHT_FLOOR:    cfg_q.floor_pct       <= cfg_wdata[6:0];
				twsc_pkg::CFG_BRIGHT_STEP:     cfg_q.step_pct        <= cfg_wdata[4:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* hw/rtl/twsc_core.sv */
// twsc_core: scene state registers, next-state logic for one event and the stage 1 register
// holding scene, brightness and the duty drive request. Depends on twsc_pkg.
module twsc_core #(
	parameter int BREATH_STEPS = twsc_pkg::BREATH_STEPS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_accept,
	input  twsc_pkg::item_t  item,
	input  twsc_pkg::cfg_t   cfg,
	output twsc_pkg::stage_t st_s1,
	output logic             v_s1
);

	localparam logic [twsc_pkg::BPOS_W-1:0] BPOS_LAST = twsc_pkg::BPOS_W'(BREATH_STEPS - 1);

	twsc_pkg::scene_t                    scene_q, scene_n, msg_scene;
	logic [twsc_pkg::BRIGHT_W-1:0]       bright_q, bright_n;
	logic                                ovr_q, ovr_n;
	logic [2:0]                          cyc_q, cyc_n;
	logic [twsc_pkg::BPOS_W-1:0]         bpos_q, bpos_n;
	twsc_pkg::drive_t                    drv;
	logic [twsc_pkg::LUX_W-1:0]          target;
	logic [twsc_pkg::LUX_W:0]            hi, lux_plus_band;
	logic [7:0]                          nb;
	twsc_pkg::stage_t                    st_n;

	always_comb begin
		scene_n       = scene_q;
		bright_n      = bright_q;
		ovr_n         = ovr_q;
		cyc_n         = cyc_q;
		bpos_n        = bpos_q;
		drv.en        = 1'b0;
		drv.base_warm = '0;
		drv.base_cool = '0;
		drv.bright    = bright_q;
		nb            = '0;
		msg_scene     = (item.scene_code > 8'd6) ? twsc_pkg::SC_CIRCADIAN
		                                         : twsc_pkg::scene_t'(item.scene_code[2:0]);
		case (scene_q)
			twsc_pkg::SC_DESTRESS: target = cfg.target_destress;
			twsc_pkg::SC_SUNSET:   target = cfg.target_sunset;
			twsc_pkg::SC_OFF:      target = '0;
			default:               target = cfg.target_default;
		endcase
		hi            = {1'b0, target} + {1'b0, cfg.band};
		lux_plus_band = {1'b0, item.lux_sample} + {1'b0, cfg.band};

		case (twsc_pkg::func_t'(item.func))
			twsc_pkg::FN_SCENE_TICK: begin
				if (!item.switch_level && !ovr_q) begin
					ovr_n         = 1'b1;
					cyc_n         = {1'b0, cyc_q[1:0]} + 3'd1;
					scene_n       = twsc_pkg::scene_t'(cyc_n);
					drv.en        = 1'b1;
					drv.base_warm = twsc_pkg::base_warm(scene_n);
					drv.base_cool = twsc_pkg::base_cool(scene_n);
				end else if (item.switch_level) begin
					ovr_n = 1'b0;
				end
				if (scene_n == twsc_pkg::SC_CIRCADIAN && !ovr_n) begin
					drv.en = 1'b1;
					if (item.hour_of_day >= 5'd6 && item.hour_of_day < 5'd9) begin
						drv.base_warm = 8'd255;
						drv.base_cool = 8'd128;
					end else if (item.hour_of_day >= 5'd9 && item.hour_of_day < 5'd17) begin
						drv.base_warm = 8'd32;
						drv.base_cool = 8'd255;
					end else if (item.hour_of_day >= 5'd17 && item.hour_of_day < 5'd21) begin
						drv.base_warm = 8'd200;
						drv.base_cool = 8'd32;
					end else begin
						drv.base_warm = 8'd0;
						drv.base_cool = 8'd0;
					end
				end
				if (scene_n == twsc_pkg::SC_BREATHING) begin
					bpos_n = (bpos_q == BPOS_LAST) ? '0 : bpos_q + 1'b1;
					if (bpos_n < 8'd40)
						nb = 8'd20 + {bpos_n[6:0], 1'b0};
					else if (bpos_n < 8'd110)
						nb = 8'd100;
					else
						nb = 8'd210 - bpos_n;
					bright_n      = nb[6:0];
					drv.en        = 1'b1;
					drv.base_warm = 8'd180;
					drv.base_cool = 8'd60;
					drv.bright    = bright_n;
				end
			end
			twsc_pkg::FN_CONTROL_TICK: begin
				if ({1'b0, item.lux_sample} > hi) begin
					if (bright_q > cfg.floor_pct) begin
						nb = (bright_q > {2'b0, cfg.step_pct})
						   ? {1'b0, bright_q - {2'b0, cfg.step_pct}} : 8'd0;
						bright_n = (nb[6:0] < cfg.floor_pct) ? cfg.floor_pct : nb[6:0];
					end
				end else if (lux_plus_band < {1'b0, target}) begin
					if (bright_q < twsc_pkg::BRIGHT_MAX) begin
						nb       = {1'b0, bright_q} + {3'b0, cfg.step_pct};
						bright_n = (nb > 8'd100) ? twsc_pkg::BRIGHT_MAX : nb[6:0];
					end
				end
				if (scene_q != twsc_pkg::SC_OFF) begin
					drv.en        = 1'b1;
					drv.base_warm = twsc_pkg::base_warm(scene_q);
					drv.base_cool = twsc_pkg::base_cool(scene_q);
					drv.bright    = bright_n;
				end
			end
			twsc_pkg::FN_LIGHTING: begin
				scene_n       = msg_scene;
				drv.en        = 1'b1;
				drv.base_warm = twsc_pkg::base_warm(msg_scene);
				drv.base_cool = twsc_pkg::base_cool(msg_scene);
				bright_n      = (item.brightness_cmd > 8'd100) ? twsc_pkg::BRIGHT_MAX
				                                               : item.brightness_cmd[6:0];
			end
			twsc_pkg::FN_STRESS: begin
				if (item.stress_value >= 8'd70 && scene_q != twsc_pkg::SC_BREATHING) begin
					scene_n       = twsc_pkg::SC_DESTRESS;
					drv.en        = 1'b1;
					drv.base_warm = twsc_pkg::base_warm(twsc_pkg::SC_DESTRESS);
					drv.base_cool = twsc_pkg::base_cool(twsc_pkg::SC_DESTRESS);
				end
			end
			twsc_pkg::FN_INTERVENTION: begin
				if (item.intervention_code == 8'd2 || item.intervention_code == 8'd4) begin
					scene_n       = twsc_pkg::SC_BREATHING;
					drv.en        = 1'b1;
					drv.base_warm = twsc_pkg::base_warm(twsc_pkg::SC_BREATHING);
					drv.base_cool = twsc_pkg::base_cool(twsc_pkg::SC_BREATHING);
				end
			end
			default: ;
		endcase

		st_n.drv    = drv;
		st_n.scene  = scene_n;
		st_n.bright = bright_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scene_q  <= twsc_pkg::SC_CIRCADIAN;
			bright_q <= 7'd80;
			ovr_q    <= 1'b0;
			cyc_q    <= 3'd1;
			bpos_q   <= '0;
		end else if (in_accept) begin
			scene_q  <= scene_n;
			bright_q <= bright_n;
			ovr_q    <= ovr_n;
			cyc_q    <= cyc_n;
			bpos_q   <= bpos_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (en)
			v_s1 <= in_accept;
	end

	always_ff @(posedge clk) begin
		if (in_accept)
			st_s1 <= st_n;
	end

endmodule

/* hw/rtl/twsc_duty.sv */
// twsc_duty: stage 2, scales the requested base duties by brightness / 100 and holds
// the warm and cool duty registers and the result payload. Depends on twsc_pkg.
module twsc_duty (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           v_s1,
	input  twsc_pkg::stage_t               st_s1,
	output logic                           v_s2,
	output logic [twsc_pkg::DUTY_W-1:0]    warm_q,
	output logic [twsc_pkg::DUTY_W-1:0]    cool_q,
	output twsc_pkg::scene_t               scene_s2,
	output logic [twsc_pkg::BRIGHT_W-1:0]  bright_s2
);

	localparam int PROD_W = twsc_pkg::DUTY_W + twsc_pkg::RECIP_W;

	logic [twsc_pkg::RECIP_W-1:0] rcp;
	logic [PROD_W-1:0]            prod_w, prod_c;

	assign rcp    = twsc_pkg::recip(st_s1.drv.bright);
	assign prod_w = PROD_W'(st_s1.drv.base_warm) * PROD_W'(rcp);
	assign prod_c = PROD_W'(st_s1.drv.base_cool) * PROD_W'(rcp);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2   <= 1'b0;
			warm_q <= 8'd102;
			cool_q <= 8'd204;
		end else if (en) begin
			v_s2 <= v_s1;
			if (v_s1 && st_s1.drv.en) begin
				warm_q <= prod_w[twsc_pkg::RECIP_SHIFT +: twsc_pkg::DUTY_W];
				cool_q <= prod_c[twsc_pkg::RECIP_SHIFT +: twsc_pkg::DUTY_W];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en && v_s1) begin
			scene_s2  <= st_s1.scene;
			bright_s2 <= st_s1.bright;
		end
	end

endmodule

/* hw/rtl/tunable_white_scene_controller_top.sv */
// tunable_white_scene_controller_top: warm/cool LED scene controller, stream in, stream out.
// Depends on twsc_pkg, twsc_cfg, twsc_core and twsc_duty.
//
// Usage:
//   Each input transaction on the s_ side is one event (tuser = event code) and produces
//   exactly one result transaction on the m_ side carrying the warm and cool PWM duties,
//   the active scene and the brightness after the event.
//   Configuration is written through cfg_we / cfg_addr / cfg_wdata, one register per
//   cycle, while no transaction is in flight.
//   A result is valid on the m_ side once it has passed stage 1 and stage 2. Stage 1 updates
//   the scene state and registers the duty request; stage 2 holds one 8x20 multiply per
//   channel that scales the base duty by brightness / 100.
//   Throughput: one transaction per cycle when not stalled; state chains event to event.
//   Stall: when m_tready is low with a result waiting, both stages hold and s_tready
//   drops in the same cycle; nothing is lost or repeated.
//   Reset (arst_n low): scene circadian, brightness 80, duties 102/204, breathing
//   position 0, configuration at its defaults, both stages empty.
module tunable_white_scene_controller_top #(
	parameter int BREATH_STEPS = twsc_pkg::BREATH_STEPS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// switch_level[0], hour_of_day[5:1], lux_sample[21:6], scene_code[29:22],
	// brightness_cmd[37:30], stress_value[45:38], intervention_code[53:46]
	input  logic [55:0]                      s_tdata,
	// func[2:0]
	input  logic [2:0]                       s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// warm_duty[7:0], cool_duty[15:8], active_scene[18:16], brightness_now[25:19]
	output logic [31:0]                      m_tdata,
	input  logic                             cfg_we,
	input  logic [twsc_pkg::CFG_ADDR_W-1:0]  cfg_addr,
	input  logic [twsc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

	logic                              en, in_accept, v_s1, v_s2;
	twsc_pkg::item_t                   item;
	twsc_pkg::cfg_t                    cfg;
	twsc_pkg::stage_t                  st_s1;
	logic [twsc_pkg::DUTY_W-1:0]       warm_q, cool_q;
	twsc_pkg::scene_t                  scene_s2;
	logic [twsc_pkg::BRIGHT_W-1:0]     bright_s2;

	assign en        = !v_s2 || m_tready;
	assign s_tready  = en;
	assign in_accept = s_tvalid && en;

	assign item.func              = s_tuser;
	assign item.switch_level      = s_tdata[0];
	assign item.hour_of_day       = s_tdata[5:1];
	assign item.lux_sample        = s_tdata[21:6];
	assign item.scene_code        = s_tdata[29:22];
	assign item.brightness_cmd    = s_tdata[37:30];
	assign item.stress_value      = s_tdata[45:38];
	assign item.intervention_code = s_tdata[53:46];

	twsc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	twsc_core #(
		.BREATH_STEPS (BREATH_STEPS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_accept (in_accept),
		.item      (item),
		.cfg       (cfg),
		.st_s1     (st_s1),
		.v_s1      (v_s1)
	);

	twsc_duty u_duty (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.v_s1      (v_s1),
		.st_s1     (st_s1),
		.v_s2      (v_s2),
		.warm_q    (warm_q),
		.cool_q    (cool_q),
		.scene_s2  (scene_s2),
		.bright_s2 (bright_s2)
	);

	assign m_tvalid = v_s2;
	assign m_tdata  = {6'b0, bright_s2, scene_s2, cool_q, warm_q};

	a_bright_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[25:19] <= 7'd100))
		else $error("brightness above 100");

	a_scene_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[18:16] != 3'd7))
		else $error("active scene out of range");

	a_stall_only: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (m_tvalid && !m_tready))
		else $error("input stalled without output backpressure");

	a_accept_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> v_s1)
		else $error("accepted transaction missing from stage 1");

endmodule
